// ----- rtl/core/qxpm_pkg.sv -----
// ----------------------------------------------------------------------------
// qxpm_pkg: shared types and constants of the quad X motor mixer
// Register indexes, widths of the lane datapath and the lane control beat.
// ----------------------------------------------------------------------------
package qxpm_pkg;

    localparam int CENTER_PULSE_DEF = 1500;
    localparam int MOTOR_MIN        = 1000;
    localparam int MOTOR_MAX        = 2000;
    localparam int RECIP_SHIFT      = 20;

    localparam int PULSE_W = 12;
    localparam int GYRO_W  = 16;
    localparam int DZ_W    = 9;
    localparam int MA_W    = 7;
    localparam int GAIN_W  = 12;
    localparam int MOTOR_W = 11;
    localparam int PROD_W  = PULSE_W + MA_W;
    localparam int ANGLE_W = 12;
    localparam int SUM_W   = GYRO_W + 1;
    localparam int MAG_W   = GYRO_W;
    localparam int QMAG_W  = MAG_W + GAIN_W - 8;
    localparam int ERR_W   = QMAG_W + 1;
    localparam int MIX_W   = ERR_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd2;

    localparam logic [DZ_W-1:0]   DEADZONE_RST   = 9'd20;
    localparam logic [MA_W-1:0]   TILT_LIMIT_RST = 7'd30;
    localparam logic [GAIN_W-1:0] GAIN_RST       = 12'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MERGE
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } lane_ctrl_t;

endpackage

// ----- rtl/core/qxpm_lane.sv -----
// ----------------------------------------------------------------------------
// qxpm_lane: one axis of the mixer
// Maps a stick pulse to an angle target, adds the gyro reading, scales by the
// gain and holds the axis error across dead band beats.
// ----------------------------------------------------------------------------
module qxpm_lane #(
    parameter int CENTER_PULSE = qxpm_pkg::CENTER_PULSE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qxpm_pkg::lane_ctrl_t               ctrl,
    input  logic [qxpm_pkg::PULSE_W-1:0]       pulse,
    input  logic signed [qxpm_pkg::GYRO_W-1:0] gyro,
    input  logic [qxpm_pkg::DZ_W-1:0]          deadzone,
    input  logic [qxpm_pkg::MA_W-1:0]          tilt_limit,
    input  logic [qxpm_pkg::GAIN_W-1:0]        gain,
    output logic signed [qxpm_pkg::ERR_W-1:0]  error
);

    localparam int D_UP   = qxpm_pkg::MOTOR_MAX - CENTER_PULSE;
    localparam int D_DN   = CENTER_PULSE - qxpm_pkg::MOTOR_MIN;
    localparam int M_UP   = (1 << qxpm_pkg::RECIP_SHIFT) / D_UP;
    localparam int M_DN   = (1 << qxpm_pkg::RECIP_SHIFT) / D_DN;
    localparam int D_W    = 10;
    localparam int M_W    = 13;
    localparam int CMP_W  = qxpm_pkg::PULSE_W + 1;
    localparam int APX_W  = qxpm_pkg::PROD_W + M_W;
    localparam int REM_W  = qxpm_pkg::PROD_W + 1;
    localparam int QP_W   = qxpm_pkg::MAG_W + qxpm_pkg::GAIN_W;

    localparam logic [CMP_W-1:0] CENTER = CMP_W'(CENTER_PULSE);
    localparam logic [D_W-1:0]   DV_UP  = D_W'(D_UP);
    localparam logic [D_W-1:0]   DV_DN  = D_W'(D_DN);
    localparam logic [M_W-1:0]   MV_UP  = M_W'(M_UP);
    localparam logic [M_W-1:0]   MV_DN  = M_W'(M_DN);

    logic [qxpm_pkg::PULSE_W-1:0]       pulse_reg;
    logic signed [qxpm_pkg::GYRO_W-1:0] gyro_reg;
    logic                               above_reg;
    logic                               below_reg;
    logic [qxpm_pkg::PULSE_W-1:0]       dist_reg;
    logic [qxpm_pkg::PROD_W-1:0]        prod_reg;
    logic [qxpm_pkg::ANGLE_W-1:0]       quot_reg;
    logic [qxpm_pkg::ANGLE_W-1:0]       angle_reg;
    logic signed [qxpm_pkg::SUM_W-1:0]  sum_reg;
    logic signed [qxpm_pkg::ERR_W-1:0]  held_reg;

    logic [CMP_W-1:0]                   pulse_x;
    logic                               above_next;
    logic                               below_next;
    logic [qxpm_pkg::PULSE_W-1:0]       dist_next;
    logic [D_W-1:0]                     div_sel;
    logic [M_W-1:0]                     recip_sel;
    logic [APX_W-1:0]                   approx;
    logic [REM_W-1:0]                   rem;
    logic [qxpm_pkg::ANGLE_W-1:0]       angle_next;
    logic signed [qxpm_pkg::SUM_W-1:0]  sum_next;
    logic                               sum_neg;
    logic [qxpm_pkg::MAG_W-1:0]         mag;
    logic [QP_W-1:0]                    qprod;
    logic [qxpm_pkg::QMAG_W-1:0]        qmag;
    logic signed [qxpm_pkg::ERR_W-1:0]  err_next;

    // dead band test and distance from center
    always_comb
    begin
        pulse_x    = {1'b0, pulse_reg};
        above_next = pulse_x >= (CENTER + CMP_W'(deadzone));
        below_next = (pulse_x + CMP_W'(deadzone)) < CENTER;
        if (above_next)
        begin
            dist_next = qxpm_pkg::PULSE_W'(pulse_x - CENTER);
        end
        else
        begin
            dist_next = qxpm_pkg::PULSE_W'(CENTER - pulse_x);
        end
    end

    // divide by the half span through a reciprocal, one correction step
    always_comb
    begin
        div_sel   = above_reg ? DV_UP : DV_DN;
        recip_sel = above_reg ? MV_UP : MV_DN;
        approx    = APX_W'(prod_reg) * APX_W'(recip_sel);
        rem       = REM_W'(prod_reg) - REM_W'(REM_W'(quot_reg) * REM_W'(div_sel));
        if (rem >= REM_W'(div_sel))
        begin
            angle_next = quot_reg + qxpm_pkg::ANGLE_W'(1);
        end
        else
        begin
            angle_next = quot_reg;
        end
        sum_next = qxpm_pkg::SUM_W'(gyro_reg)
                 + $signed({1'b0, qxpm_pkg::ANGLE_W'(angle_reg)});
    end

    // gain scaling, truncated toward zero, sign flipped below center
    always_comb
    begin
        sum_neg = sum_reg[qxpm_pkg::SUM_W-1];
        mag     = sum_neg ? qxpm_pkg::MAG_W'(-sum_reg) : qxpm_pkg::MAG_W'(sum_reg);
        qprod   = QP_W'(mag) * QP_W'(gain);
        qmag    = qprod[QP_W-1:8];
        if (sum_neg ^ below_reg)
        begin
            err_next = -$signed({1'b0, qmag});
        end
        else
        begin
            err_next = $signed({1'b0, qmag});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pulse_reg <= pulse;
            gyro_reg  <= gyro;
        end
        above_reg <= above_next;
        below_reg <= below_next;
        dist_reg  <= dist_next;
        prod_reg  <= qxpm_pkg::PROD_W'(dist_reg) * qxpm_pkg::PROD_W'(tilt_limit);
        quot_reg  <= qxpm_pkg::ANGLE_W'(approx >> qxpm_pkg::RECIP_SHIFT);
        angle_reg <= angle_next;
        sum_reg   <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctrl.commit && (above_reg || below_reg))
        begin
            held_reg <= err_next;
        end
    end

    assign error = held_reg;

endmodule

// ----- rtl/core/qxpm_merge.sv -----
// ----------------------------------------------------------------------------
// qxpm_merge: X mix of the two axis errors
// Forms the four motor sums, clamps them and holds them in the output
// register until the beat is taken.
// ----------------------------------------------------------------------------
module qxpm_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [qxpm_pkg::PULSE_W-1:0]       throttle,
    input  logic signed [qxpm_pkg::ERR_W-1:0]  roll_error,
    input  logic signed [qxpm_pkg::ERR_W-1:0]  pitch_error,
    output logic                               slot_free,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [qxpm_pkg::MOTOR_W-1:0]       motor_one,
    output logic [qxpm_pkg::MOTOR_W-1:0]       motor_two,
    output logic [qxpm_pkg::MOTOR_W-1:0]       motor_three,
    output logic [qxpm_pkg::MOTOR_W-1:0]       motor_four
);

    localparam int W = qxpm_pkg::MIX_W;

    function automatic logic [qxpm_pkg::MOTOR_W-1:0] clamp_motor(
        input logic signed [W-1:0] v
    );
        logic [qxpm_pkg::MOTOR_W-1:0] r;
        if (v < W'(qxpm_pkg::MOTOR_MIN))
        begin
            r = qxpm_pkg::MOTOR_W'(qxpm_pkg::MOTOR_MIN);
        end
        else if (v > W'(qxpm_pkg::MOTOR_MAX))
        begin
            r = qxpm_pkg::MOTOR_W'(qxpm_pkg::MOTOR_MAX);
        end
        else
        begin
            r = v[qxpm_pkg::MOTOR_W-1:0];
        end
        return r;
    endfunction

    logic                               valid_reg;
    logic [qxpm_pkg::MOTOR_W-1:0]       m1_reg;
    logic [qxpm_pkg::MOTOR_W-1:0]       m2_reg;
    logic [qxpm_pkg::MOTOR_W-1:0]       m3_reg;
    logic [qxpm_pkg::MOTOR_W-1:0]       m4_reg;
    logic signed [W-1:0]                thr;
    logic signed [W-1:0]                r;
    logic signed [W-1:0]                p;

    always_comb
    begin
        thr = $signed({{(W-qxpm_pkg::PULSE_W){1'b0}}, throttle});
        r   = W'(roll_error);
        p   = W'(pitch_error);
    end

    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m1_reg <= clamp_motor(thr + r - p);
            m2_reg <= clamp_motor(thr - r - p);
            m3_reg <= clamp_motor(thr + r + p);
            m4_reg <= clamp_motor(thr - r + p);
        end
    end

    assign out_valid   = valid_reg;
    assign motor_one   = m1_reg;
    assign motor_two   = m2_reg;
    assign motor_three = m3_reg;
    assign motor_four  = m4_reg;

endmodule

// ----- rtl/core/quad_x_p_mixer.sv -----
// ----------------------------------------------------------------------------
// quad_x_p_mixer: proportional attitude mixer for an X quadcopter
// An input beat is taken only when idle; the lane datapath then runs
// and the output is loaded once its register is free. No new beat is taken
// before that load; the held axis errors feed the next beat.
// Reset: async active low; held errors clear to zero, registers go to
// deadzone 20, tilt_limit 30, gain 256.
// ----------------------------------------------------------------------------
module quad_x_p_mixer #(
    parameter int CENTER_PULSE = qxpm_pkg::CENTER_PULSE_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qxpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qxpm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [qxpm_pkg::PULSE_W-1:0]          throttle_pulse,
    input  logic [qxpm_pkg::PULSE_W-1:0]          roll_pulse,
    input  logic [qxpm_pkg::PULSE_W-1:0]          pitch_pulse,
    input  logic signed [qxpm_pkg::GYRO_W-1:0]    gyro_roll,
    input  logic signed [qxpm_pkg::GYRO_W-1:0]    gyro_pitch,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [qxpm_pkg::MOTOR_W-1:0]          motor_one,
    output logic [qxpm_pkg::MOTOR_W-1:0]          motor_two,
    output logic [qxpm_pkg::MOTOR_W-1:0]          motor_three,
    output logic [qxpm_pkg::MOTOR_W-1:0]          motor_four
);

    localparam logic [2:0] LAST_STEP = 3'd5;

    qxpm_pkg::state_t                   state_reg;
    qxpm_pkg::state_t                   state_next;
    logic [2:0]                         cnt_reg;
    logic [2:0]                         cnt_next;
    logic [qxpm_pkg::DZ_W-1:0]          deadzone_reg;
    logic [qxpm_pkg::MA_W-1:0]          tilt_limit_reg;
    logic [qxpm_pkg::GAIN_W-1:0]        gain_reg;
    logic [qxpm_pkg::PULSE_W-1:0]       throttle_reg;
    qxpm_pkg::lane_ctrl_t               lane_ctrl;
    logic                               merge_load;
    logic                               slot_free;
    logic                               accept;
    logic signed [qxpm_pkg::ERR_W-1:0]  roll_error;
    logic signed [qxpm_pkg::ERR_W-1:0]  pitch_error;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg   <= qxpm_pkg::DEADZONE_RST;
            tilt_limit_reg <= qxpm_pkg::TILT_LIMIT_RST;
            gain_reg       <= qxpm_pkg::GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qxpm_pkg::REG_DEADZONE:   deadzone_reg   <= cfg_data[qxpm_pkg::DZ_W-1:0];
                qxpm_pkg::REG_TILT_LIMIT: tilt_limit_reg <= cfg_data[qxpm_pkg::MA_W-1:0];
                qxpm_pkg::REG_GAIN:       gain_reg       <= cfg_data[qxpm_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            qxpm_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = qxpm_pkg::ST_RUN;
                end
            end
            qxpm_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = qxpm_pkg::ST_MERGE;
                end
            end
            qxpm_pkg::ST_MERGE:
            begin
                if (slot_free)
                begin
                    state_next = qxpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qxpm_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready         = 1'b0;
        lane_ctrl.load   = 1'b0;
        lane_ctrl.commit = 1'b0;
        merge_load       = 1'b0;
        unique case (state_reg)
            qxpm_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                lane_ctrl.load = in_valid;
            end
            qxpm_pkg::ST_RUN:
            begin
                lane_ctrl.commit = cnt_reg == LAST_STEP;
            end
            qxpm_pkg::ST_MERGE:
            begin
                merge_load = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qxpm_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            throttle_reg <= throttle_pulse;
        end
    end

    qxpm_lane #(
        .CENTER_PULSE (CENTER_PULSE)
    ) u_lane_roll (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .pulse      (roll_pulse),
        .gyro       (gyro_roll),
        .deadzone   (deadzone_reg),
        .tilt_limit (tilt_limit_reg),
        .gain       (gain_reg),
        .error      (roll_error)
    );

    qxpm_lane #(
        .CENTER_PULSE (CENTER_PULSE)
    ) u_lane_pitch (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .pulse      (pitch_pulse),
        .gyro       (gyro_pitch),
        .deadzone   (deadzone_reg),
        .tilt_limit (tilt_limit_reg),
        .gain       (gain_reg),
        .error      (pitch_error)
    );

    qxpm_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (merge_load),
        .throttle    (throttle_reg),
        .roll_error  (roll_error),
        .pitch_error (pitch_error),
        .slot_free   (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .motor_one   (motor_one),
        .motor_two   (motor_two),
        .motor_three (motor_three),
        .motor_four  (motor_four)
    );

endmodule
